>>> sv/alarm_input_qualifier_unit_assert.svh
// Assertion macros for the alarm input qualifier unit.
`ifndef ALARM_INPUT_QUALIFIER_UNIT_ASSERT_SVH
`define ALARM_INPUT_QUALIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define AIQU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aiqu check failed: consequent false in same cycle");

// Next-cycle implication, checked outside reset.
`define AIQU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aiqu check failed: consequent false in next cycle");

`endif

>>> sv/aiqu_pkg.sv
// Shared types and constants for the alarm input qualifier.
package aiqu_pkg;

   // Field widths fixed by the interface
   localparam int LINE_WIDTH       = 10;
   localparam int CONFIRM_WIDTH    = 2;
   localparam int CSR_INDEX_WIDTH  = 1;
   localparam int CSR_DATA_WIDTH   = LINE_WIDTH;
   localparam int DEFAULT_NUM_LINES = 10;

   // Register reset values
   localparam logic [LINE_WIDTH-1:0]    NORMAL_RESET  = 10'd858;
   localparam logic [CONFIRM_WIDTH-1:0] CONFIRM_RESET = 2'd3;

   // Lines with a fixed meaning
   localparam int POWER_LINE  = 0;
   localparam int GATE_LINE   = 2;
   localparam int WPOWER_LINE = 5;
   localparam int SMOKE_LINE  = 7;
   localparam int WATER_LINE  = 9;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_NORMAL_PATTERN = 1'b0,
      CSR_CONFIRM_COUNT  = 1'b1
   } csr_index_type;

   // One result word
   typedef struct packed {
      logic [LINE_WIDTH-1:0] alarm_flags;
      logic                  water_loss;
      logic                  smoke_alarm;
      logic                  gate_open;
      logic                  water_power;
      logic                  power_loss;
      logic                  power_cut;
   } result_type;

endpackage

>>> sv/aiqu_lane.sv
// One debounce lane: confirm counter and alarm flag for a single line.
module aiqu_lane (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic                              level,
   input  logic                              normal,
   input  logic [aiqu_pkg::CONFIRM_WIDTH-1:0] confirm,
   output logic                              flag_next,
   output logic                              flag_q
);
   import aiqu_pkg::*;

   logic [CONFIRM_WIDTH-1:0] count_ff;
   logic [CONFIRM_WIDTH-1:0] count_in;
   logic [CONFIRM_WIDTH-1:0] count_inc;
   logic                     flag_ff;
   logic                     flag_in;
   logic                     alarm;

   assign alarm     = level ^ normal;
   assign count_inc = count_ff + CONFIRM_WIDTH'(1);

   // Count alarm-level scans; clear at once on a normal-level scan
   always_comb begin
      count_in = count_ff;
      flag_in  = flag_ff;
      if (accept) begin
         if (alarm) begin
            if (!flag_ff) begin
               if ((count_inc >= confirm) || (count_inc == '0)) begin
                  count_in = '0;
                  flag_in  = 1'b1;
               end else begin
                  count_in = count_inc;
               end
            end
         end else begin
            count_in = '0;
            flag_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         flag_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         flag_ff  <= flag_in;
      end
   end

   assign flag_next = flag_in;
   assign flag_q    = flag_ff;

endmodule

>>> sv/aiqu_merge.sv
// Merge stage: decodes lane flags, holds the power-loss latch and buffers result words.
module aiqu_merge #(
   parameter int NUM_LINES = aiqu_pkg::DEFAULT_NUM_LINES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [NUM_LINES-1:0]   flags_next,
   input  logic                   out_stall,
   output logic                   out_valid,
   output aiqu_pkg::result_type   out_word,
   output logic                   in_stall
);
   import aiqu_pkg::*;

   logic       water;
   logic       smoke;
   logic       latch_ff;
   logic       latch_in;
   result_type new_word;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_word_ff;
   result_type out_word_in;
   logic       skid_valid_ff;
   logic       skid_valid_in;
   result_type skid_word_ff;
   result_type skid_word_in;
   logic       out_take;

   assign water = flags_next[WATER_LINE];
   assign smoke = flags_next[SMOKE_LINE];

   // Follow line 0 only while neither smoke nor water loss is active
   always_comb begin
      latch_in = latch_ff;
      if (accept && !water && !smoke) begin
         latch_in = flags_next[POWER_LINE];
      end
   end

   // Build the result word of the accepted scan
   always_comb begin
      new_word.alarm_flags = flags_next[LINE_WIDTH-1:0];
      new_word.water_loss  = water;
      new_word.smoke_alarm = smoke;
      new_word.gate_open   = flags_next[GATE_LINE];
      new_word.water_power = flags_next[WPOWER_LINE];
      new_word.power_loss  = latch_in;
      new_word.power_cut   = water | smoke;
   end

   assign out_take = out_valid_ff && !out_stall;

   // Output register plus skid word: refill from skid first, else park the new word
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (!out_valid_ff || out_take) begin
         out_valid_in  = skid_valid_ff || accept;
         out_word_in   = skid_valid_ff ? skid_word_ff : new_word;
         skid_valid_in = 1'b0;
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_word_in  = new_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff      <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         latch_ff      <= latch_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;
   assign in_stall  = skid_valid_ff;

endmodule

>>> sv/alarm_input_qualifier_unit.sv
// Alarm input qualifier top level: configuration registers, debounce lanes and merge stage.
//
// Usage:
//   req_*  : one scan of the raw alarm lines per word, taken when req_valid is high
//            and req_stall is low.
//   rsp_*  : one result word per scan (qualified flags and decoded alarms), taken
//            when rsp_valid is high and rsp_stall is low.
//   csr_*  : register writes (index 0 normal_pattern, index 1 confirm_count);
//            csr_ready is always high. Write only while the block is idle.
// Result: each scan's word is registered, in the skid word while an output word is held.
// Throughput: one scan per cycle while req_stall is low; every lane updates its counter and
//   flag in the cycle the scan is taken, so each scan sees the state the previous one left.
// Stall: an output register and a skid word sit behind the merge stage; scans keep
//   flowing while one result waits, and req_stall rises once both hold a word.
// Reset: counters, flags and the power-loss latch clear, the buffers empty, and
//   the registers return to normal_pattern 858 and confirm_count 3.
`include "alarm_input_qualifier_unit_assert.svh"

module alarm_input_qualifier_unit #(
   parameter int NUM_LINES = aiqu_pkg::DEFAULT_NUM_LINES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [aiqu_pkg::LINE_WIDTH-1:0]      req_raw_lines,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [aiqu_pkg::LINE_WIDTH-1:0]      rsp_alarm_flags,
   output logic                                rsp_water_loss,
   output logic                                rsp_smoke_alarm,
   output logic                                rsp_gate_open,
   output logic                                rsp_water_power,
   output logic                                rsp_power_loss,
   output logic                                rsp_power_cut,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [aiqu_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [aiqu_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import aiqu_pkg::*;

   logic [LINE_WIDTH-1:0]    normal_pattern_ff;
   logic [LINE_WIDTH-1:0]    normal_pattern_in;
   logic [CONFIRM_WIDTH-1:0] confirm_count_ff;
   logic [CONFIRM_WIDTH-1:0] confirm_count_in;
   logic                     req_accept;
   logic [NUM_LINES-1:0]     raw_ext;
   logic [NUM_LINES-1:0]     normal_ext;
   logic [NUM_LINES-1:0]     alarm_vec;
   logic [NUM_LINES-1:0]     flags_next;
   logic [NUM_LINES-1:0]     flags_q;
   result_type               rsp_word;

   assign csr_ready = 1'b1;

   // Register writes
   always_comb begin
      normal_pattern_in = normal_pattern_ff;
      confirm_count_in  = confirm_count_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_NORMAL_PATTERN: normal_pattern_in = csr_wdata[LINE_WIDTH-1:0];
            CSR_CONFIRM_COUNT:  confirm_count_in  = csr_wdata[CONFIRM_WIDTH-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_pattern_ff <= NORMAL_RESET;
         confirm_count_ff  <= CONFIRM_RESET;
      end else begin
         normal_pattern_ff <= normal_pattern_in;
         confirm_count_ff  <= confirm_count_in;
      end
   end

   assign req_accept = req_valid && !req_stall;

   // Lines past the interface width read level 0 with normal level 0
   assign raw_ext    = NUM_LINES'(req_raw_lines);
   assign normal_ext = NUM_LINES'(normal_pattern_ff);
   assign alarm_vec  = raw_ext ^ normal_ext;

   // One lane per line
   for (genvar i = 0; i < NUM_LINES; i++) begin : g_lane
      aiqu_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .accept    (req_accept),
         .level     (raw_ext[i]),
         .normal    (normal_ext[i]),
         .confirm   (confirm_count_ff),
         .flag_next (flags_next[i]),
         .flag_q    (flags_q[i])
      );
   end

   aiqu_merge #(
      .NUM_LINES (NUM_LINES)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .flags_next (flags_next),
      .out_stall  (rsp_stall),
      .out_valid  (rsp_valid),
      .out_word   (rsp_word),
      .in_stall   (req_stall)
   );

   assign rsp_alarm_flags = rsp_word.alarm_flags;
   assign rsp_water_loss  = rsp_word.water_loss;
   assign rsp_smoke_alarm = rsp_word.smoke_alarm;
   assign rsp_gate_open   = rsp_word.gate_open;
   assign rsp_water_power = rsp_word.water_power;
   assign rsp_power_loss  = rsp_word.power_loss;
   assign rsp_power_cut   = rsp_word.power_cut;

   // The skid word fills only behind a held output word
   `AIQU_ASSERT_NOW(a_stall_needs_held_word, clock, reset, req_stall, rsp_valid)
   // A set flag stays set while its line keeps the alarm level
   `AIQU_ASSERT_NOW(a_flag_sticks, clock, reset, req_accept, ((flags_q & alarm_vec & ~flags_next) == '0))
   // After a scan, no line at its normal level keeps a flag
   `AIQU_ASSERT_NEXT(a_normal_clears, clock, reset, req_accept, ((flags_q & ~$past(alarm_vec)) == '0))

endmodule
